/* src/msort_pkg.sv */
// ----------------------------------------------------------------------------
// msort_pkg
// Shared types and codes of the merge insertion sorter: value and status
// widths, result status codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package msort_pkg;

    localparam int VALUE_W  = 31;
    localparam int STATUS_W = 3;

    typedef logic [VALUE_W-1:0]  value_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_SINGLE    = 3'd1;
    localparam status_t ST_DUPLICATE = 3'd2;
    localparam status_t ST_ORDERED   = 3'd3;
    localparam status_t ST_OVERFLOW  = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // input transfer taken
        logic read_prev;   // read the entry just below the insert position
        logic shift;       // move that entry up one place
        logic place;       // write the new value at the insert position
        logic check_dup;   // compare the entry read with the new value
        logic err_load;    // load an error result into the output register
        logic out_start;   // rewind the output index
        logic out_read;    // read the entry at the output index
        logic out_load;    // load the entry read into the output register
        logic out_next;    // advance the output index
        logic clear;       // return the set state to its reset value
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic insert;        // the current value is to be stored
        logic pos_zero;      // insert position reached the bottom
        logic prev_greater;  // entry read is greater than the new value
        logic last;          // the current value closed the set
        logic error;         // the closed set is rejected
        logic out_last;      // output index points at the final entry
        logic out_taken;     // the output register was transferred
    } sts_t;

endpackage

/* src/msort_datapath.sv */
// ----------------------------------------------------------------------------
// msort_datapath
// Value store, set bookkeeping, insertion pointer and output register.
// ----------------------------------------------------------------------------
module msort_datapath #(
    parameter int MAX_ITEMS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  msort_pkg::cmd_t   cmd,
    output msort_pkg::sts_t   sts,
    input  msort_pkg::value_t in_value,
    input  logic              in_last,
    output msort_pkg::value_t out_value,
    output msort_pkg::status_t out_status,
    output logic              out_last,
    output logic              out_valid,
    input  logic              out_ready
);
    import msort_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 2);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ITEMS);
    localparam logic [CW-1:0] CNT_OVF = CW'(MAX_ITEMS + 1);
    localparam logic [CW-1:0] CNT_ONE = CW'(1);

    value_t mem [MAX_ITEMS];

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          dup_reg, dup_next;
    logic          asc_reg, asc_next;
    logic          ins_reg, ins_next;
    logic          last_reg, last_next;
    value_t        prev_reg, prev_next;
    value_t        val_reg, val_next;
    value_t        rd_data_reg;

    logic          ovalid_reg, ovalid_next;
    value_t        ovalue_reg, ovalue_next;
    status_t       ostatus_reg, ostatus_next;
    logic          olast_reg, olast_next;

    logic          mem_we;
    logic [AW-1:0] mem_wa;
    value_t        mem_wd;
    logic          mem_re;
    logic [AW-1:0] mem_ra;
    logic [CW-1:0] pos_dec;
    logic [CW-1:0] idx_inc;
    status_t       err_code;
    logic          taken;

    assign pos_dec = pos_reg - CNT_ONE;
    assign idx_inc = idx_reg + CNT_ONE;
    assign taken   = ovalid_reg && out_ready;

    always_comb
    begin
        priority if (count_reg > CNT_MAX)
        begin
            err_code = ST_OVERFLOW;
        end
        else if (count_reg == CNT_ONE)
        begin
            err_code = ST_SINGLE;
        end
        else if (dup_reg)
        begin
            err_code = ST_DUPLICATE;
        end
        else if (asc_reg)
        begin
            err_code = ST_ORDERED;
        end
        else
        begin
            err_code = ST_OK;
        end
    end

    assign mem_we = cmd.shift || cmd.place;
    assign mem_wa = pos_reg[AW-1:0];
    assign mem_wd = cmd.shift ? rd_data_reg : val_reg;
    assign mem_re = cmd.read_prev || cmd.out_read;
    assign mem_ra = cmd.read_prev ? pos_dec[AW-1:0] : idx_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    always_comb
    begin
        count_next   = count_reg;
        pos_next     = pos_reg;
        idx_next     = idx_reg;
        dup_next     = dup_reg;
        asc_next     = asc_reg;
        ins_next     = ins_reg;
        last_next    = last_reg;
        prev_next    = prev_reg;
        val_next     = val_reg;
        ovalid_next  = ovalid_reg;
        ovalue_next  = ovalue_reg;
        ostatus_next = ostatus_reg;
        olast_next   = olast_reg;

        if (cmd.load)
        begin
            val_next  = in_value;
            last_next = in_last;
            prev_next = in_value;
            if (count_reg < CNT_MAX)
            begin
                if ((count_reg != '0) && (in_value <= prev_reg))
                begin
                    asc_next = 1'b0;
                end
                count_next = count_reg + CNT_ONE;
                pos_next   = count_reg;
                ins_next   = 1'b1;
            end
            else
            begin
                count_next = CNT_OVF;
                ins_next   = 1'b0;
            end
        end
        if (cmd.shift)
        begin
            pos_next = pos_dec;
        end
        if (cmd.place)
        begin
            ins_next = 1'b0;
        end
        if (cmd.check_dup && (rd_data_reg == val_reg))
        begin
            dup_next = 1'b1;
        end
        if (cmd.out_start)
        begin
            idx_next = '0;
        end
        if (cmd.out_next)
        begin
            idx_next = idx_inc;
        end
        if (taken)
        begin
            ovalid_next = 1'b0;
        end
        if (cmd.err_load)
        begin
            ovalid_next  = 1'b1;
            ovalue_next  = '0;
            ostatus_next = err_code;
            olast_next   = 1'b1;
        end
        if (cmd.out_load)
        begin
            ovalid_next  = 1'b1;
            ovalue_next  = rd_data_reg;
            ostatus_next = ST_OK;
            olast_next   = (idx_inc == count_reg);
        end
        if (cmd.clear)
        begin
            count_next = '0;
            dup_next   = 1'b0;
            asc_next   = 1'b1;
            prev_next  = '0;
            ins_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            dup_reg    <= 1'b0;
            asc_reg    <= 1'b1;
            prev_reg   <= '0;
            ins_reg    <= 1'b0;
            last_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            dup_reg    <= dup_next;
            asc_reg    <= asc_next;
            prev_reg   <= prev_next;
            ins_reg    <= ins_next;
            last_reg   <= last_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        idx_reg     <= idx_next;
        val_reg     <= val_next;
        ovalue_reg  <= ovalue_next;
        ostatus_reg <= ostatus_next;
        olast_reg   <= olast_next;
    end

    always_comb
    begin
        sts.insert       = ins_reg;
        sts.pos_zero     = (pos_reg == '0);
        sts.prev_greater = (rd_data_reg > val_reg);
        sts.last         = last_reg;
        sts.error        = (err_code != ST_OK);
        sts.out_last     = (idx_inc == count_reg);
        sts.out_taken    = taken;
    end

    assign out_value  = ovalue_reg;
    assign out_status = ostatus_reg;
    assign out_last   = olast_reg;
    assign out_valid  = ovalid_reg;

endmodule

/* src/msort_ctrl.sv */
// ----------------------------------------------------------------------------
// msort_ctrl
// Sequencer of the sorter: takes one value, walks it down the sorted store,
// then at the end of a set streams the store out or reports an error.
// ----------------------------------------------------------------------------
module msort_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  msort_pkg::sts_t sts,
    output msort_pkg::cmd_t cmd
);
    import msort_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SEEK  = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_END   = 3'd3;
    localparam logic [2:0] S_ORD   = 3'd4;
    localparam logic [2:0] S_OLD   = 3'd5;
    localparam logic [2:0] S_OWAIT = 3'd6;
    localparam logic [2:0] S_ERRW  = 3'd7;

    logic [2:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SEEK;
                end
            end
            S_SEEK:
            begin
                priority if (!sts.insert)
                begin
                    state_next = S_END;
                end
                else if (sts.pos_zero)
                begin
                    cmd.place  = 1'b1;
                    state_next = S_END;
                end
                else
                begin
                    cmd.read_prev = 1'b1;
                    state_next    = S_CMP;
                end
            end
            S_CMP:
            begin
                if (sts.prev_greater)
                begin
                    cmd.shift  = 1'b1;
                    state_next = S_SEEK;
                end
                else
                begin
                    // The first entry not above the value decides a duplicate.
                    cmd.place     = 1'b1;
                    cmd.check_dup = 1'b1;
                    state_next    = S_END;
                end
            end
            S_END:
            begin
                priority if (!sts.last)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.error)
                begin
                    cmd.err_load = 1'b1;
                    state_next   = S_ERRW;
                end
                else
                begin
                    cmd.out_start = 1'b1;
                    state_next    = S_ORD;
                end
            end
            S_ORD:
            begin
                cmd.out_read = 1'b1;
                state_next   = S_OLD;
            end
            S_OLD:
            begin
                cmd.out_load = 1'b1;
                state_next   = S_OWAIT;
            end
            S_OWAIT:
            begin
                if (sts.out_taken)
                begin
                    if (sts.out_last)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.out_next = 1'b1;
                        state_next   = S_ORD;
                    end
                end
            end
            S_ERRW:
            begin
                if (sts.out_taken)
                begin
                    cmd.clear  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* src/merge_insertion_sorter.sv */
// ----------------------------------------------------------------------------
// merge_insertion_sorter
// Collects a set of values and returns them in ascending order, or one
// result with an error status when the set is rejected.
// ----------------------------------------------------------------------------
// Input stream (s_axis): one value per transfer, tlast on the final value.
// Output stream (m_axis): one sorted value per transfer, tlast on the final
// one; tuser carries the status (0 ok, 1 single value, 2 duplicate,
// 3 already ascending, 4 more than MAX_ITEMS values). A rejected set gives
// a single transfer with value 0, the status and tlast.
// Each value is inserted into a sorted single-port memory by moving larger
// entries up one place; every entry moved takes a registered read, then a
// compare and write.
// After the final value the store is read out one result at a time: each
// entry is read, loaded into the output register, and the next entry is
// read only after that result is taken. s_axis_tready is low while a value
// is being inserted and while the set is read out. A stalled receiver
// holds the output register and the read-out simply waits.
// Reset empties the set; the value memory needs no clearing pass because
// only entries written in the current set are ever read.
// ----------------------------------------------------------------------------
module merge_insertion_sorter #(
    parameter int MAX_ITEMS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [30:0] value, [31] zero
    input  logic        s_axis_tlast,   // last_item
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [30:0] sorted_value, [31] zero
    output logic [2:0]  m_axis_tuser,   // [2:0] status
    output logic        m_axis_tlast    // last_result
);
    import msort_pkg::*;

    cmd_t    cmd;
    sts_t    sts;
    value_t  out_value;
    status_t out_status;

    msort_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    msort_datapath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_value   (s_axis_tdata[VALUE_W-1:0]),
        .in_last    (s_axis_tlast),
        .out_value  (out_value),
        .out_status (out_status),
        .out_last   (m_axis_tlast),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready)
    );

    assign m_axis_tdata = {1'b0, out_value};
    assign m_axis_tuser = out_status;

    // The block never takes input while a result is waiting.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input accepted while a result is pending");

    // An error result is the only result of its set and carries value zero.
    a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_OK)) |->
            (m_axis_tlast && (m_axis_tdata == 32'd0)))
        else $error("malformed error result");

    // After the final result of a set leaves, the block returns to taking input.
    a_return_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("block did not return to idle after the set");

endmodule
